// ===== rtl/cct_pkg.sv =====
// completion counter table: shared request codes, status codes and control struct
// no dependencies
package cct_pkg;

	localparam int CID_W = 10;
	localparam int SEQ_W = 32;
	localparam int AMT_W = 32;

	typedef enum logic [2:0] {
		REQ_CREATE     = 3'd0,
		REQ_SIGNAL     = 3'd1,
		REQ_CHECK      = 3'd2,
		REQ_WAIT_BEGIN = 3'd3,
		REQ_WAIT_END   = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_POOL_EMPTY = 2'd1,
		STAT_STALE      = 2'd2,
		STAT_UNDERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic    ent_we;
		logic    pop;
		logic    push;
		status_t status;
		logic    is_done;
		logic    must_wait;
		logic    fired;
		logic    released;
	} upd_ctl_t;

endpackage

// ===== rtl/cct_ram.sv =====
// completion counter table: simple dual-port synchronous ram, registered read
// no dependencies
module cct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/cct_update.sv =====
// completion counter table: modify step of the read-modify-write for one request
// depends on cct_pkg
module cct_update import cct_pkg::*; #(
	parameter int NUM_COUNTERS = 1024,
	parameter int TAG_BITS     = 32,
	parameter int REF_BITS     = 16,
	parameter int ID_W         = 10
) (
	input  logic [2:0]          req,
	input  logic [ID_W-1:0]     addr,
	input  logic                in_range,
	input  logic [SEQ_W-1:0]    seq_tag,
	input  logic [AMT_W-1:0]    amount,
	input  logic [TAG_BITS-1:0] ent_tag,
	input  logic [AMT_W-1:0]    ent_count,
	input  logic [REF_BITS-1:0] ent_ref,
	input  logic [ID_W-1:0]     stk_id,
	input  logic [ID_W:0]       free_top,
	input  logic [TAG_BITS-1:0] last_tag,
	output upd_ctl_t            ctl,
	output logic [ID_W-1:0]     wr_addr,
	output logic [TAG_BITS-1:0] wr_tag,
	output logic [AMT_W-1:0]    wr_count,
	output logic [REF_BITS-1:0] wr_ref,
	output logic [TAG_BITS-1:0] new_tag,
	output logic [ID_W:0]       free_top_next,
	output logic [CID_W-1:0]    handle_id,
	output logic [SEQ_W-1:0]    handle_seq
);

	localparam int TW = (TAG_BITS > SEQ_W) ? TAG_BITS : SEQ_W;
	localparam int AW = (ID_W > CID_W) ? ID_W : CID_W;

	logic                tag_match;
	logic [TAG_BITS-1:0] tag_inc;
	logic [REF_BITS-1:0] ref_dec;
	logic                drop_rel;
	logic                can_push;
	logic [TW-1:0]       new_tag_w;
	logic [AW-1:0]       stk_id_w;

	assign tag_match = (seq_tag != '0) && in_range && (TW'(ent_tag) == TW'(seq_tag));
	assign tag_inc   = last_tag + 1'b1;
	assign new_tag   = (tag_inc == '0) ? TAG_BITS'(1) : tag_inc;
	assign ref_dec   = (ent_ref != '0) ? ent_ref - 1'b1 : '0;
	assign drop_rel  = (ref_dec == '0);
	assign can_push  = free_top < (ID_W+1)'(NUM_COUNTERS);
	assign new_tag_w = TW'(new_tag);
	assign stk_id_w  = AW'(stk_id);

	always_comb begin
		ctl        = '0;
		ctl.status = STAT_OK;
		wr_addr    = addr;
		wr_tag     = ent_tag;
		wr_count   = ent_count;
		wr_ref     = ent_ref;
		handle_id  = '0;
		handle_seq = '0;
		case (req)
			REQ_CREATE: begin
				if (free_top == '0) begin
					ctl.status = STAT_POOL_EMPTY;
				end else begin
					ctl.pop    = 1'b1;
					ctl.ent_we = 1'b1;
					wr_addr    = stk_id;
					wr_tag     = new_tag;
					wr_count   = amount;
					wr_ref     = REF_BITS'(1);
					handle_id  = stk_id_w[CID_W-1:0];
					handle_seq = new_tag_w[SEQ_W-1:0];
				end
			end
			REQ_SIGNAL: begin
				if (!tag_match) begin
					ctl.status = STAT_STALE;
				end else if (amount > ent_count) begin
					ctl.status = STAT_UNDERFLOW;
				end else begin
					ctl.ent_we = 1'b1;
					wr_count   = ent_count - amount;
					if (ent_count == amount) begin
						ctl.fired = 1'b1;
						wr_ref    = ref_dec;
						if (drop_rel) begin
							ctl.released = 1'b1;
							ctl.push     = can_push;
							wr_tag       = '0;
							wr_count     = '0;
						end
					end
				end
			end
			REQ_CHECK: begin
				ctl.is_done = !tag_match;
			end
			REQ_WAIT_BEGIN: begin
				if (!tag_match) begin
					ctl.status = STAT_STALE;
				end else begin
					ctl.ent_we    = 1'b1;
					wr_ref        = (ent_ref != '1) ? ent_ref + 1'b1 : ent_ref;
					ctl.must_wait = (ent_count != '0);
				end
			end
			REQ_WAIT_END: begin
				if (!tag_match) begin
					ctl.status = STAT_STALE;
				end else begin
					ctl.ent_we = 1'b1;
					wr_ref     = ref_dec;
					if (drop_rel) begin
						ctl.released = 1'b1;
						ctl.push     = can_push;
						wr_tag       = '0;
						wr_count     = '0;
					end
				end
			end
			default: begin
				ctl.status = STAT_OK;
			end
		endcase
	end

	always_comb begin
		if (ctl.pop) begin
			free_top_next = free_top - 1'b1;
		end else if (ctl.push) begin
			free_top_next = free_top + 1'b1;
		end else begin
			free_top_next = free_top;
		end
	end

endmodule

// ===== rtl/completion_counter_table.sv =====
// Completion counter table. Takes one request per cycle while req_stall is
// low and returns a registered response. Each request reads the entry memory
// (tag, count, references) and the free-id stack in the accept cycle, then
// modifies and writes both back when stage 1 advances; a last-write register
// per memory forwards data when consecutive requests touch the same entry or
// stack slot. After reset a clearing pass over all NUM_COUNTERS entries zeroes
// the entry memory and refills the free-id stack; requests are stalled during
// that pass. Depends on cct_pkg, cct_ram and cct_update.
module completion_counter_table import cct_pkg::*; #(
	parameter int NUM_COUNTERS = 1024,
	parameter int TAG_BITS     = 32,
	parameter int REF_BITS     = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic [2:0]       req_type,
	input  logic [CID_W-1:0] counter_id,
	input  logic [SEQ_W-1:0] seq_tag,
	input  logic [AMT_W-1:0] amount,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output logic [1:0]       status,
	output logic [CID_W-1:0] handle_id,
	output logic [SEQ_W-1:0] handle_seq,
	output logic             is_done,
	output logic             must_wait,
	output logic             fired,
	output logic             released
);

	localparam int ID_W = $clog2(NUM_COUNTERS);
	localparam int AW   = (ID_W > CID_W) ? ID_W : CID_W;
	localparam int EW   = TAG_BITS + AMT_W + REF_BITS;

	// clearing pass
	logic            clr_q;
	logic [ID_W-1:0] clr_idx_q;

	// handshake
	logic accept;
	logic s1_adv;

	// stage 1
	logic             s1_valid;
	logic [2:0]       s1_req;
	logic [ID_W-1:0]  s1_addr;
	logic             s1_in_range;
	logic [SEQ_W-1:0] s1_tag;
	logic [AMT_W-1:0] s1_amt;
	logic [ID_W-1:0]  s1_stk_addr;

	// state registers
	logic [ID_W:0]       free_top_q;
	logic [TAG_BITS-1:0] next_tag_q;

	// forwarding
	logic            ewr_valid_q;
	logic [ID_W-1:0] ewr_addr_q;
	logic [EW-1:0]   ewr_data_q;
	logic            swr_valid_q;
	logic [ID_W-1:0] swr_addr_q;
	logic [ID_W-1:0] swr_data_q;

	// memory ports
	logic            ent_we;
	logic [ID_W-1:0] ent_waddr;
	logic [EW-1:0]   ent_wdata;
	logic [ID_W-1:0] ent_raddr;
	logic [EW-1:0]   ent_rdata;
	logic            stk_we;
	logic [ID_W-1:0] stk_waddr;
	logic [ID_W-1:0] stk_wdata;
	logic [ID_W-1:0] stk_raddr;
	logic [ID_W-1:0] stk_rdata;

	// modify step
	logic [AW-1:0]       cid_w;
	logic                cid_in_range;
	logic [EW-1:0]       ent_cur;
	logic [ID_W-1:0]     stk_cur;
	upd_ctl_t            ctl;
	logic [ID_W-1:0]     upd_addr;
	logic [TAG_BITS-1:0] upd_tag;
	logic [AMT_W-1:0]    upd_count;
	logic [REF_BITS-1:0] upd_ref;
	logic [TAG_BITS-1:0] upd_new_tag;
	logic [ID_W:0]       upd_free_top;
	logic [CID_W-1:0]    upd_handle_id;
	logic [SEQ_W-1:0]    upd_handle_seq;
	logic [ID_W:0]       ft_sel;
	logic [ID_W:0]       ft_m1;

	// response register
	logic             rsp_valid_q;
	status_t          status_q;
	logic [CID_W-1:0] handle_id_q;
	logic [SEQ_W-1:0] handle_seq_q;
	logic             is_done_q;
	logic             must_wait_q;
	logic             fired_q;
	logic             released_q;

	assign s1_adv    = s1_valid && (!rsp_valid_q || !rsp_stall);
	assign req_stall = clr_q || (s1_valid && !s1_adv);
	assign accept    = req_valid && !req_stall;

	assign cid_w        = AW'(counter_id);
	assign cid_in_range = 32'(counter_id) < 32'(NUM_COUNTERS);
	assign ent_raddr    = cid_w[ID_W-1:0];

	// stack read address follows the top as updated by the request in stage 1
	assign ft_sel    = s1_adv ? upd_free_top : free_top_q;
	assign ft_m1     = ft_sel - 1'b1;
	assign stk_raddr = ft_m1[ID_W-1:0];

	assign ent_we    = clr_q || (s1_adv && ctl.ent_we);
	assign ent_waddr = clr_q ? clr_idx_q : upd_addr;
	assign ent_wdata = clr_q ? '0 : {upd_tag, upd_count, upd_ref};
	assign stk_we    = clr_q || (s1_adv && ctl.push);
	assign stk_waddr = clr_q ? clr_idx_q : free_top_q[ID_W-1:0];
	assign stk_wdata = clr_q ? (ID_W'(NUM_COUNTERS - 1) - clr_idx_q) : s1_addr;

	assign ent_cur = (ewr_valid_q && ewr_addr_q == s1_addr) ? ewr_data_q : ent_rdata;
	assign stk_cur = (swr_valid_q && swr_addr_q == s1_stk_addr) ? swr_data_q : stk_rdata;

	cct_ram #(
		.WIDTH (EW),
		.DEPTH (NUM_COUNTERS)
	) u_ent_ram (
		.clk     (clk),
		.wr_en   (ent_we),
		.wr_addr (ent_waddr),
		.wr_data (ent_wdata),
		.rd_en   (accept),
		.rd_addr (ent_raddr),
		.rd_data (ent_rdata)
	);

	cct_ram #(
		.WIDTH (ID_W),
		.DEPTH (NUM_COUNTERS)
	) u_stk_ram (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_waddr),
		.wr_data (stk_wdata),
		.rd_en   (accept),
		.rd_addr (stk_raddr),
		.rd_data (stk_rdata)
	);

	cct_update #(
		.NUM_COUNTERS (NUM_COUNTERS),
		.TAG_BITS     (TAG_BITS),
		.REF_BITS     (REF_BITS),
		.ID_W         (ID_W)
	) u_update (
		.req           (s1_req),
		.addr          (s1_addr),
		.in_range      (s1_in_range),
		.seq_tag       (s1_tag),
		.amount        (s1_amt),
		.ent_tag       (ent_cur[EW-1 -: TAG_BITS]),
		.ent_count     (ent_cur[REF_BITS +: AMT_W]),
		.ent_ref       (ent_cur[REF_BITS-1:0]),
		.stk_id        (stk_cur),
		.free_top      (free_top_q),
		.last_tag      (next_tag_q),
		.ctl           (ctl),
		.wr_addr       (upd_addr),
		.wr_tag        (upd_tag),
		.wr_count      (upd_count),
		.wr_ref        (upd_ref),
		.new_tag       (upd_new_tag),
		.free_top_next (upd_free_top),
		.handle_id     (upd_handle_id),
		.handle_seq    (upd_handle_seq)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
			s1_valid    <= 1'b0;
			free_top_q  <= (ID_W+1)'(NUM_COUNTERS);
			next_tag_q  <= TAG_BITS'(1);
			ewr_valid_q <= 1'b0;
			swr_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == ID_W'(NUM_COUNTERS - 1)) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				free_top_q <= upd_free_top;
				if (ctl.pop) begin
					next_tag_q <= upd_new_tag;
				end
				if (ctl.ent_we) begin
					ewr_valid_q <= 1'b1;
				end
				if (ctl.push) begin
					swr_valid_q <= 1'b1;
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_req      <= req_type;
			s1_addr     <= ent_raddr;
			s1_in_range <= cid_in_range;
			s1_tag      <= seq_tag;
			s1_amt      <= amount;
			s1_stk_addr <= stk_raddr;
		end
		if (s1_adv) begin
			if (ctl.ent_we) begin
				ewr_addr_q <= upd_addr;
				ewr_data_q <= {upd_tag, upd_count, upd_ref};
			end
			if (ctl.push) begin
				swr_addr_q <= free_top_q[ID_W-1:0];
				swr_data_q <= s1_addr;
			end
			status_q     <= ctl.status;
			handle_id_q  <= upd_handle_id;
			handle_seq_q <= upd_handle_seq;
			is_done_q    <= ctl.is_done;
			must_wait_q  <= ctl.must_wait;
			fired_q      <= ctl.fired;
			released_q   <= ctl.released;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign handle_id  = handle_id_q;
	assign handle_seq = handle_seq_q;
	assign is_done    = is_done_q;
	assign must_wait  = must_wait_q;
	assign fired      = fired_q;
	assign released   = released_q;

	a_free_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_top_q <= (ID_W+1)'(NUM_COUNTERS))
		else $error("free stack top beyond table size");

	a_tag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		next_tag_q != '0)
		else $error("tag counter reached zero");

	a_release_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && released_q |-> status_q == STAT_OK && !is_done_q)
		else $error("release reported with error status");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && ctl.pop |=> free_top_q == $past(free_top_q) - 1'b1)
		else $error("pop did not lower the stack top");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !s1_adv |=> s1_valid && $stable(s1_addr) && $stable(s1_req))
		else $error("stalled request in stage 1 changed");

endmodule
